// ===== rtl/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants for the nearest palette color block
// Component widths, the distance width, the tag that follows an entry through
// the search pipeline and the opcodes of an input word.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int DEFAULT_ENTRIES = 256;
    localparam int IN_W            = 8;
    localparam int CH_W            = 6;
    localparam int SQ_W            = 2 * CH_W;
    localparam int DIST_W          = SQ_W + 2;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } color_t;

    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

// ===== rtl/npc_palette.sv =====
// ----------------------------------------------------------------------------
// npc_palette: palette memory
// One write port for loads and one registered read port for the search.
// Entries that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module npc_palette #(
    parameter int ENTRIES = npc_pkg::DEFAULT_ENTRIES,
    parameter int AW      = $clog2(ENTRIES)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  npc_pkg::color_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output npc_pkg::color_t rd_data
);
    import npc_pkg::*;

    color_t             mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    color_t             rd_mem_reg;
    logic               rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_hit_reg <= valid_reg[rd_addr];
        end
    end

    // An entry that has not been loaded since reset reads as black.
    assign rd_data = rd_hit_reg ? rd_mem_reg : '0;

endmodule

// ===== rtl/npc_dist.sv =====
// ----------------------------------------------------------------------------
// npc_dist: squared distance unit
// Computes the squared Euclidean distance between the query color and one
// palette entry per cycle, registered together with the entry's index and tag.
// ----------------------------------------------------------------------------
module npc_dist #(
    parameter int AW = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  npc_pkg::tag_t                in_tag,
    input  logic [AW-1:0]                in_idx,
    input  npc_pkg::color_t              query,
    input  npc_pkg::color_t              entry,
    output npc_pkg::tag_t                out_tag,
    output logic [AW-1:0]                out_idx,
    output logic [npc_pkg::DIST_W-1:0]   out_dist
);
    import npc_pkg::*;

    logic [CH_W-1:0]   dr, dg, db;
    logic [SQ_W-1:0]   sr, sg, sb;
    logic [DIST_W-1:0] sq_sum;
    tag_t              tag_reg;
    logic [AW-1:0]     idx_reg;
    logic [DIST_W-1:0] dist_reg;

    always_comb
    begin
        dr     = (query.r >= entry.r) ? (query.r - entry.r) : (entry.r - query.r);
        dg     = (query.g >= entry.g) ? (query.g - entry.g) : (entry.g - query.g);
        db     = (query.b >= entry.b) ? (query.b - entry.b) : (entry.b - query.b);
        sr     = SQ_W'(dr) * SQ_W'(dr);
        sg     = SQ_W'(dg) * SQ_W'(dg);
        sb     = SQ_W'(db) * SQ_W'(db);
        sq_sum = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= in_idx;
        dist_reg <= sq_sum;
    end

    assign out_tag  = tag_reg;
    assign out_idx  = idx_reg;
    assign out_dist = dist_reg;

endmodule

// ===== rtl/nearest_palette_color.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color: nearest palette entry search
// Holds a palette of 6-bit RGB entries and returns, for a query color, the
// index of the entry with the smallest squared Euclidean distance.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one word per item. An
// opcode of load writes the low 6 bits of red, green and blue into palette
// entry entry_index and gives no result; a load beyond the palette size is
// dropped. A load does not stall the input.
// An opcode of query shifts each 8-bit component right by two and sweeps
// the whole palette, one entry per cycle through the single read port of
// the palette memory and a shared distance unit. The result word on the
// output channel (out_valid / out_stall) carries nearest_index; on equal
// distances the lowest index wins.
// A query holds the input stalled through the sweep, the memory read stage,
// the distance stage and the done state, until the result is handed to the
// output register; the result word is offered from that register.
// The output register parts the two sides: while a result waits under
// out_stall the block keeps taking loads and may start the next query;
// that query's result then waits inside until the output register is free.
// Reset clears the control state and marks every palette entry as not
// loaded, so the whole palette reads as black; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_palette_color #(
    parameter int PALETTE_ENTRIES = npc_pkg::DEFAULT_ENTRIES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     opcode,
    input  logic [npc_pkg::IN_W-1:0] entry_index,
    input  logic [npc_pkg::IN_W-1:0] red,
    input  logic [npc_pkg::IN_W-1:0] green,
    input  logic [npc_pkg::IN_W-1:0] blue,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [npc_pkg::IN_W-1:0] nearest_index
);
    import npc_pkg::*;

    localparam int            AW   = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(PALETTE_ENTRIES - 1);

    // The sequencer walks from idle into the sweep on a query, and parks
    // the finished index in the done state until the output register frees.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic accept;
    logic start;
    logic in_range;
    logic load_en;

    logic          issuing_reg;
    logic [AW-1:0] addr_reg;
    tag_t          tag1_reg;
    logic [AW-1:0] idx1_reg;
    color_t        query_reg;
    color_t        load_color;
    color_t        rd_data;

    tag_t              tag2;
    logic [AW-1:0]     idx2;
    logic [DIST_W-1:0] dist2;

    logic [DIST_W-1:0] best_dist_reg;
    logic [AW-1:0]     best_idx_reg;
    logic [AW-1:0]     result_reg;
    logic              win;
    logic              finish;
    logic              hand_off;

    logic            out_valid_reg;
    logic [IN_W-1:0] out_idx_reg;

    // Handshake and decode of the input word.
    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign start      = accept && (opcode == OP_QUERY);
    assign in_range   = ({1'b0, entry_index} < (IN_W + 1)'(PALETTE_ENTRIES));
    assign load_en    = accept && (opcode == OP_LOAD) && in_range;
    assign load_color = '{r: red[CH_W-1:0], g: green[CH_W-1:0], b: blue[CH_W-1:0]};

    // The last distance of a sweep closes the query; the done state hands the
    // index over once the output register is empty or being drained.
    assign win      = (dist2 < best_dist_reg);
    assign finish   = (state_reg == S_SCAN) && tag2.valid && tag2.last;
    assign hand_off = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (finish)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (hand_off)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issuing_reg   <= 1'b0;
            addr_reg      <= '0;
            tag1_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Address sequencer of the sweep.
            if (start)
            begin
                issuing_reg <= 1'b1;
                addr_reg    <= '0;
            end
            else if (issuing_reg)
            begin
                if (addr_reg == LAST)
                begin
                    issuing_reg <= 1'b0;
                end
                else
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
            end

            // The tag lines up with the registered read data of the memory.
            tag1_reg <= '{valid: issuing_reg, last: (addr_reg == LAST)};

            if (hand_off)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= addr_reg;

        if (start)
        begin
            query_reg     <= '{r: red[IN_W-1:2], g: green[IN_W-1:2], b: blue[IN_W-1:2]};
            best_dist_reg <= DIST_MAX;
            best_idx_reg  <= '0;
        end
        else if (tag2.valid && win)
        begin
            // Strict compare keeps the lowest index on equal distances.
            best_dist_reg <= dist2;
            best_idx_reg  <= idx2;
        end

        if (finish)
        begin
            result_reg <= win ? idx2 : best_idx_reg;
        end

        if (hand_off)
        begin
            out_idx_reg <= IN_W'(result_reg);
        end
    end

    npc_palette #(
        .ENTRIES (PALETTE_ENTRIES),
        .AW      (AW)
    ) u_palette (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_en),
        .wr_addr (entry_index[AW-1:0]),
        .wr_data (load_color),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    npc_dist #(
        .AW (AW)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (tag1_reg),
        .in_idx   (idx1_reg),
        .query    (query_reg),
        .entry    (rd_data),
        .out_tag  (tag2),
        .out_idx  (idx2),
        .out_dist (dist2)
    );

    assign out_valid     = out_valid_reg;
    assign nearest_index = out_idx_reg;

endmodule

// ===== tb/tb_nearest_palette_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color: self-checking testbench for the palette search
// Drives palette loads and nearest color queries, predicts every nearest_index
// with a software copy of the palette and checks each result word in order.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color;
    import npc_pkg::*;

    localparam int     CLK_PERIOD   = 10;
    localparam int     ENTRIES      = DEFAULT_ENTRIES;
    localparam int     MAX_GAP      = 12;
    localparam int     RANDOM_WORDS = 1500;
    localparam int     PHASE_WORDS  = RANDOM_WORDS / 4;
    localparam int     HOLD_CYCLES  = 2000;
    localparam int     HOLD_QUERIES = 6;
    localparam int     DRAIN_CYCLES = ENTRIES + 40;
    // The limit is set well above the length of the slowest correct run.
    localparam longint CYCLE_LIMIT  = 2_500_000;

    // Scoreboard: a private copy of the palette and the queue of best indices
    // that the accepted queries are owed, oldest first.
    class palette_scoreboard;
        color_t          palette [ENTRIES];
        logic [IN_W-1:0] pending_best [$];
        int              mismatches;
        int              loads;
        int              queries;
        int              compared;

        function new();
            foreach (palette[i]) palette[i] = '0;
            mismatches = 0;
            loads      = 0;
            queries    = 0;
            compared   = 0;
        endfunction

        function int pending();
            return pending_best.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // A load updates the palette copy; a query searches it for the entry
        // with the smallest squared distance, keeping the first one on ties.
        function void note_input_word(logic op, logic [IN_W-1:0] idx,
                                      logic [IN_W-1:0] rd, logic [IN_W-1:0] gr,
                                      logic [IN_W-1:0] bl);
            int best;
            int best_dist;
            int sq_sum;
            int dr;
            int dg;
            int db;
            if (op == OP_LOAD) begin
                loads++;
                if (int'(idx) < ENTRIES)
                    palette[idx] = '{r: rd[CH_W-1:0], g: gr[CH_W-1:0], b: bl[CH_W-1:0]};
            end
            else begin
                queries++;
                best      = 0;
                best_dist = 32'h7fff_ffff;
                for (int i = 0; i < ENTRIES; i++) begin
                    dr     = int'(rd[IN_W-1:2]) - int'(palette[i].r);
                    dg     = int'(gr[IN_W-1:2]) - int'(palette[i].g);
                    db     = int'(bl[IN_W-1:2]) - int'(palette[i].b);
                    sq_sum = dr * dr + dg * dg + db * db;
                    if (sq_sum < best_dist) begin
                        best_dist = sq_sum;
                        best      = i;
                    end
                end
                pending_best.push_back(best[IN_W-1:0]);
            end
        endfunction

        task check_result_word(logic [IN_W-1:0] got);
            logic [IN_W-1:0] want;
            if (pending_best.size() == 0) begin
                report_mismatch($sformatf("nearest_index %0d with no query outstanding", got));
            end
            else begin
                want = pending_best.pop_front();
                compared++;
                if (got !== want)
                    report_mismatch($sformatf("nearest_index got %0d, expected %0d", got,
                                              want));
            end
        endtask
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic            opcode;
    logic [IN_W-1:0] entry_index;
    logic [IN_W-1:0] red;
    logic [IN_W-1:0] green;
    logic [IN_W-1:0] blue;
    logic            out_valid;
    logic            out_stall;
    logic [IN_W-1:0] nearest_index;

    // Shared controls between the stimulus and the result sink. When idle_on
    // is low neither side inserts gaps; hold_request asks the sink for one
    // long stall.
    bit                idle_on = 1'b1;
    bit                hold_request = 1'b0;
    palette_scoreboard sb = new();

    always #(CLK_PERIOD / 2) clk = ~clk;

    nearest_palette_color u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .nearest_index (nearest_index)
    );

    // Offer one word after a random gap and hold it until the block takes it.
    // The task returns in the time step of acceptance, so the caller must
    // either offer the next word or drop in_valid before time moves on.
    task automatic send_word(logic op, logic [IN_W-1:0] idx, logic [IN_W-1:0] rd,
                             logic [IN_W-1:0] gr, logic [IN_W-1:0] bl);
        int gap;
        gap = idle_on ? int'($urandom_range(MAX_GAP, 0)) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        entry_index <= idx;
        red         <= rd;
        green       <= gr;
        blue        <= bl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input_word(op, idx, rd, gr, bl);
    endtask

    // Result sink. Before each word it stalls for a random number of cycles,
    // or for one long stretch when hold_request is raised, then takes the
    // next word that the block offers and hands it to the scoreboard.
    initial
    begin : result_sink
        int stall_cycles;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall_cycles = HOLD_CYCLES;
            end
            else begin
                stall_cycles = idle_on ? int'($urandom_range(MAX_GAP, 0)) : 0;
            end
            if (stall_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid && !hold_request) @(posedge clk);
            if (out_valid)
                sb.check_result_word(nearest_index);
        end
    end

    // Watchdog: a run that has not ended by the cycle limit is a failure.
    initial
    begin : watchdog
        longint cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped at the cycle limit of %0d cycles.", CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        logic            op;
        logic [IN_W-1:0] idx;
        logic [IN_W-1:0] rd;
        logic [IN_W-1:0] gr;
        logic [IN_W-1:0] bl;
        logic [5:0]      low_bits;
        color_t          pick;
        int              phase;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = OP_LOAD;
        entry_index = '0;
        red         = '0;
        green       = '0;
        blue        = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words. A freshly reset palette is all black, so any query
        // must return entry 0 until something else is loaded.
        send_word(OP_QUERY, 8'd0,   8'h00, 8'h00, 8'h00);
        send_word(OP_QUERY, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        // Top entry loaded with all bits set: the two high bits are dropped.
        send_word(OP_LOAD,  8'd255, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_QUERY, 8'd0,   8'hFF, 8'hFF, 8'hFF);
        // Same white at entry 10: on the tie the lower index has to win.
        send_word(OP_LOAD,  8'd10,  8'h3F, 8'h3F, 8'h3F);
        send_word(OP_QUERY, 8'd77,  8'hFC, 8'hFC, 8'hFC);
        // High bits alone on a load leave the entry black.
        send_word(OP_LOAD,  8'd0,   8'hC0, 8'h80, 8'h40);
        // The two low query bits are shifted out before the search.
        send_word(OP_QUERY, 8'd0,   8'h03, 8'h03, 8'h03);
        // Exact match in the middle of the palette.
        send_word(OP_LOAD,  8'd128, 8'h2A, 8'h15, 8'h3F);
        send_word(OP_QUERY, 8'd128, 8'hA8, 8'h54, 8'hFC);
        send_word(OP_QUERY, 8'd1,   8'h80, 8'h00, 8'h00);
        // One saturated primary per entry, each found by its own query.
        send_word(OP_LOAD,  8'd200, 8'h3F, 8'h00, 8'h00);
        send_word(OP_LOAD,  8'd201, 8'h00, 8'h3F, 8'h00);
        send_word(OP_LOAD,  8'd202, 8'h00, 8'h00, 8'h3F);
        send_word(OP_QUERY, 8'd0,   8'hFF, 8'h00, 8'h00);
        send_word(OP_QUERY, 8'd0,   8'h00, 8'hFF, 8'h00);
        send_word(OP_QUERY, 8'd0,   8'h00, 8'h00, 8'hFF);
        send_word(OP_QUERY, 8'd0,   8'hFF, 8'hFF, 8'h00);
        // A white at entry 1 now beats both earlier whites on the tie.
        send_word(OP_LOAD,  8'd1,   8'hBF, 8'h7F, 8'hFF);
        send_word(OP_QUERY, 8'd255, 8'hFF, 8'hFF, 8'hFF);

        // Random words in four phases: a coarse palette that makes ties
        // common, a fully random palette, a stretch with no idling on either
        // side, and a last mixed phase.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            phase = n / PHASE_WORDS;
            if (n == 2 * PHASE_WORDS) begin
                // Let every owed result drain, then make the sink hold off
                // while back-to-back queries fill the block and stall its input.
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0) @(posedge clk);
                idle_on      = 1'b0;
                hold_request = 1'b1;
                for (int k = 0; k < HOLD_QUERIES; k++)
                    send_word(OP_QUERY, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom));
            end
            idle_on = (phase != 2);

            op  = ($urandom_range(99, 0) < 40) ? OP_QUERY : OP_LOAD;
            idx = 8'($urandom);
            rd  = 8'($urandom);
            gr  = 8'($urandom);
            bl  = 8'($urandom);
            if (op == OP_LOAD) begin
                if (phase == 0) begin
                    // Four levels per component keep many entries identical.
                    rd[5:0] = 6'(21 * $urandom_range(3, 0));
                    gr[5:0] = 6'(21 * $urandom_range(3, 0));
                    bl[5:0] = 6'(21 * $urandom_range(3, 0));
                end
            end
            else begin
                case ($urandom_range(3, 0))
                    0: begin
                        // Color of an existing entry with random low bits,
                        // which finds that entry or an earlier equal one.
                        pick     = sb.palette[$urandom_range(ENTRIES - 1, 0)];
                        low_bits = 6'($urandom);
                        rd       = {pick.r, low_bits[1:0]};
                        gr       = {pick.g, low_bits[3:2]};
                        bl       = {pick.b, low_bits[5:4]};
                    end
                    1: begin
                        rd = $urandom_range(1, 0) ? 8'hFF : 8'h00;
                        gr = $urandom_range(1, 0) ? 8'hFF : 8'h00;
                        bl = $urandom_range(1, 0) ? 8'hFF : 8'h00;
                    end
                    default: ;
                endcase
            end
            send_word(op, idx, rd, gr, bl);
        end

        in_valid <= 1'b0;
        idle_on = 1'b1;
        while (sb.pending() != 0) @(posedge clk);
        // Any stray result word would show up during this drain wait.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d palette loads and %0d queries; %0d results compared.",
                 sb.loads, sb.queries, sb.compared);
        $display("It included a long output hold-off, a full drain and an idle-free stretch.");
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/npc_pkg.sv
rtl/npc_palette.sv
rtl/npc_dist.sv
rtl/nearest_palette_color.sv
tb/tb_nearest_palette_color.sv
